@@ design/wsd_pkg.sv @@
package wsd_pkg;

    // parse phase of the receive side
    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_EXT16 = 3'd2,
        PH_EXT64 = 3'd3,
        PH_KEY   = 3'd4,
        PH_DATA  = 3'd5
    } t_phase;

    localparam logic [7:0] FIN_BIT      = 8'h80;
    localparam logic [7:0] MASK_BIT     = 8'h80;
    localparam logic [6:0] LEN_EXT16    = 7'd126;
    localparam logic [6:0] LEN_EXT64    = 7'd127;
    localparam logic [3:0] OP_CLOSE     = 4'h8;
    localparam logic [2:0] EXT16_LAST   = 3'd1;
    localparam logic [2:0] EXT64_LAST   = 3'd7;
    localparam logic [2:0] KEY_LAST     = 3'd3;
    localparam int         TUSER_WIDTH  = 8;

    // one result item
    typedef struct packed {
        logic       has_byte;
        logic [7:0] payload_byte;
        logic       frame_end;
        logic       message_end;
        logic [3:0] frame_opcode;
        logic       close_seen;
    } t_result;

endpackage

@@ design/wsd_parser.sv @@
module wsd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    output logic              o_res_valid,
    output wsd_pkg::t_result  o_res
);

    wsd_pkg::t_phase r_phase, n_phase;
    logic            r_fin, n_fin;
    logic [3:0]      r_op, n_op;
    logic            r_mask, n_mask;
    logic [63:0]     r_rem, n_rem;
    logic [2:0]      r_hbc, n_hbc;
    logic [31:0]     r_key, n_key;
    logic [1:0]      r_midx, n_midx;
    logic            r_closed, n_closed;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= wsd_pkg::PH_HDR0;
            r_fin    <= 1'b0;
            r_op     <= 4'h0;
            r_mask   <= 1'b0;
            r_rem    <= 64'd0;
            r_hbc    <= 3'd0;
            r_key    <= 32'd0;
            r_midx   <= 2'd0;
            r_closed <= 1'b0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_fin    <= n_fin;
            r_op     <= n_op;
            r_mask   <= n_mask;
            r_rem    <= n_rem;
            r_hbc    <= n_hbc;
            r_key    <= n_key;
            r_midx   <= n_midx;
            r_closed <= n_closed;
        end
    end

    // next state and result for the byte on the input
    always_comb begin
        logic [63:0] len_val;
        logic [63:0] rem_dec;
        logic        len_done;
        logic        hdr_done;
        logic        fend;
        logic [7:0]  kb;

        n_phase  = r_phase;
        n_fin    = r_fin;
        n_op     = r_op;
        n_mask   = r_mask;
        n_rem    = r_rem;
        n_hbc    = r_hbc;
        n_key    = r_key;
        n_midx   = r_midx;
        n_closed = r_closed;
        len_val  = r_rem;
        rem_dec  = r_rem - 64'd1;
        len_done = 1'b0;
        hdr_done = 1'b0;
        fend     = 1'b0;
        kb       = 8'h00;
        o_res_valid = 1'b0;
        o_res.has_byte     = 1'b0;
        o_res.payload_byte = 8'h00;

        if (!r_closed) begin
            case (r_phase)
                wsd_pkg::PH_HDR1: begin
                    n_mask = |(i_byte & wsd_pkg::MASK_BIT);
                    n_hbc  = 3'd0;
                    if (i_byte[6:0] == wsd_pkg::LEN_EXT16) begin
                        n_rem   = 64'd0;
                        n_phase = wsd_pkg::PH_EXT16;
                    end else if (i_byte[6:0] == wsd_pkg::LEN_EXT64) begin
                        n_rem   = 64'd0;
                        n_phase = wsd_pkg::PH_EXT64;
                    end else begin
                        len_val  = {57'd0, i_byte[6:0]};
                        n_rem    = len_val;
                        len_done = 1'b1;
                    end
                end
                wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
                    len_val = {r_rem[55:0], i_byte};
                    n_rem   = len_val;
                    if (r_hbc == ((r_phase == wsd_pkg::PH_EXT16) ?
                                  wsd_pkg::EXT16_LAST : wsd_pkg::EXT64_LAST)) begin
                        len_done = 1'b1;
                    end else begin
                        n_hbc = r_hbc + 3'd1;
                    end
                end
                wsd_pkg::PH_KEY: begin
                    n_key[{r_hbc[1:0], 3'b000} +: 8] = r_key[{r_hbc[1:0], 3'b000} +: 8] | i_byte;
                    if (r_hbc >= wsd_pkg::KEY_LAST) begin
                        hdr_done = 1'b1;
                    end else begin
                        n_hbc = r_hbc + 3'd1;
                    end
                end
                wsd_pkg::PH_DATA: begin
                    kb     = r_mask ? r_key[{r_midx, 3'b000} +: 8] : 8'h00;
                    n_midx = r_midx + 2'd1;
                    n_rem  = rem_dec;
                    fend   = (rem_dec == 64'd0);
                    o_res_valid        = 1'b1;
                    o_res.has_byte     = 1'b1;
                    o_res.payload_byte = i_byte ^ kb;
                end
                default: begin
                    n_fin   = |(i_byte & wsd_pkg::FIN_BIT);
                    n_op    = i_byte[3:0];
                    n_phase = wsd_pkg::PH_HDR1;
                end
            endcase

            // length known: key next if masked, else header complete
            if (len_done) begin
                if (n_mask) begin
                    n_hbc   = 3'd0;
                    n_key   = 32'd0;
                    n_phase = wsd_pkg::PH_KEY;
                end else begin
                    hdr_done = 1'b1;
                end
            end

            // header complete: empty-frame marker or start of payload
            if (hdr_done) begin
                if (len_val == 64'd0) begin
                    fend        = 1'b1;
                    o_res_valid = 1'b1;
                end else begin
                    n_midx  = 2'd0;
                    n_phase = wsd_pkg::PH_DATA;
                end
            end
        end

        o_res.frame_end    = fend;
        o_res.message_end  = fend & r_fin;
        o_res.frame_opcode = r_op;
        o_res.close_seen   = fend & r_fin & (r_op == wsd_pkg::OP_CLOSE);

        // end of frame returns to the first header byte
        if (fend) begin
            n_phase = wsd_pkg::PH_HDR0;
            if (o_res.close_seen) begin
                n_closed = 1'b1;
            end
        end
    end

endmodule

@@ design/wsd_out_reg.sv @@
module wsd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  wsd_pkg::t_result  i_res,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output logic              o_free,
    output wsd_pkg::t_result  o_res
);

    logic             r_valid;
    wsd_pkg::t_result r_res;

    // slot frees when empty or when the held result transfers this cycle
    assign o_free = !r_valid || i_m_tready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_res      = r_res;

endmodule

@@ design/websocket_frame_deframer.sv @@
// WebSocket receive-side deframer: takes one received byte per transfer on the
// slave stream, follows the frame header (fin, opcode, mask bit, 7-bit, 16-bit
// or 64-bit length, optional masking key) and puts out each payload byte
// unmasked on the master stream, with tlast on the last byte of a frame. A
// frame of zero length gives a single marker with has_byte low. Header bytes
// give no output. After a final close frame ends, all further bytes are taken
// and dropped until reset. One byte is accepted every clock while the output
// keeps up. A result is registered and shows on the master side in the cycle
// after its byte transfers. While a result waits unread, the slave side
// stalls for every byte, header bytes included, and takes the next byte in
// the cycle the waiting result transfers. The 64-bit length decrement and
// zero test set the critical path.
module websocket_frame_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // rx_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // payload_byte
    output logic       o_m_tlast,   // frame_end
    output logic [wsd_pkg::TUSER_WIDTH-1:0] o_m_tuser
                                    // has_byte, message_end, frame_opcode[3:0],
                                    // close_seen, zero
);

    logic             accept;
    logic             res_valid;
    logic             free;
    wsd_pkg::t_result res;
    wsd_pkg::t_result out_res;

    assign o_s_tready = free;
    assign accept     = i_s_tvalid && free;

    // header parse and unmasking
    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_s_tdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output register
    wsd_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept && res_valid),
        .i_res      (res),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_free     (free),
        .o_res      (out_res)
    );

    // pack master stream
    assign o_m_tdata = out_res.payload_byte;
    assign o_m_tlast = out_res.frame_end;
    assign o_m_tuser = {1'b0, out_res.close_seen, out_res.frame_opcode,
                        out_res.message_end, out_res.has_byte};

endmodule
